### rtl/tpfc_pkg.sv
package tpfc_pkg;

    localparam int TABLE_DEPTH_DEF = 512;
    localparam int NUMBER_BITS_DEF = 24;
    localparam int COUNT_W = 10;
    localparam int INDEX_W = 9;
    localparam int VALUE_W = 16;
    localparam int NUM_W = 24;
    localparam int KIND_W = 2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PRIME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TWO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

    typedef struct packed {
        logic action;
        logic [INDEX_W-1:0] table_index;
        logic [VALUE_W-1:0] prime_value;
        logic [NUM_W-1:0] number;
    } t_in_word;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NUM_W-1:0] smaller_prime;
        logic [NUM_W-1:0] larger_prime;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

### rtl/tpfc_ram.sv
module tpfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tpfc_div.sv
module tpfc_div #(
    parameter int NB = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpfc_pkg::t_div_ctl   i_ctl,
    input  logic [NB-1:0]        i_num,
    input  logic [NB-1:0]        i_den,
    output logic                 o_done,
    output logic [NB-1:0]        o_quo,
    output logic [NB-1:0]        o_rem
);
    import tpfc_pkg::*;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_q, n_q;
    logic [NB-1:0] r_r, n_r;
    logic [NB-1:0] r_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_run, n_run, r_done, n_done;
    logic [NB:0] w_sh;

    always_comb begin
        n_q = r_q;
        n_r = r_r;
        n_cnt = r_cnt;
        n_run = r_run;
        n_done = 1'b0;
        w_sh = {r_r, r_q[NB-1]};
        if (i_ctl.start) begin
            n_q = i_num;
            n_r = '0;
            n_cnt = CW'(NB);
            n_run = 1'b1;
        end else if (r_run) begin
            if (w_sh >= {1'b0, r_d}) begin
                n_r = NB'(w_sh - {1'b0, r_d});
                n_q = {r_q[NB-2:0], 1'b1};
            end else begin
                n_r = w_sh[NB-1:0];
                n_q = {r_q[NB-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_run = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_run <= n_run;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_ctl.start) begin
            r_d <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo = r_q;
    assign o_rem = r_r;
endmodule

### rtl/two_prime_factor_classifier.sv
// channel | signals                    | accepted when
// in      | i_in_valid o_in_ready      | valid and ready high
// out     | o_out_valid i_out_ready    | valid and ready high
// cfg     | i_cfg_valid o_cfg_ready    | valid and ready high
// a load writes one table entry; a classify reads the table entries in order and
// divides by each entry of 2 or more whose square does not exceed what remains,
// one extra division for each power divided out; the table holds 512 entries by default
// the result waits in an output register; the next word is taken meanwhile
// reset is synchronous active low; the table is undefined until written
module two_prime_factor_classifier #(
    parameter int TABLE_DEPTH = tpfc_pkg::TABLE_DEPTH_DEF,
    parameter int NUMBER_BITS = tpfc_pkg::NUMBER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tpfc_pkg::t_in_word        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tpfc_pkg::t_out_word       o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tpfc_pkg::COUNT_W-1:0] i_cfg_data
);
    import tpfc_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NB = NUMBER_BITS;
    localparam int IW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_TEST = 6'b000100,
        S_DIV  = 6'b001000,
        S_DONE = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic [IW-1:0] r_idx, n_idx, w_limit;
    logic [NB-1:0] r_rem, n_rem, r_f0, n_f0, r_f1, n_f1, r_p, n_p;
    logic [1:0] r_nf, n_nf;
    logic r_hit, n_hit, r_many, n_many;
    logic r_ovalid, n_ovalid;
    t_out_word r_out, n_out;
    logic [VALUE_W-1:0] w_rdata;
    logic w_we;
    t_div_ctl w_dctl;
    logic w_ddone;
    logic [NB-1:0] w_quo, w_drem;
    logic [2*VALUE_W-1:0] w_sq;
    logic [NB-1:0] w_lo, w_hi;
    logic [1:0] w_tot;

    assign w_limit = (IW'(r_count) > IW'(TABLE_DEPTH) || COUNT_W > IW)
        ? ((32'(r_count) > TABLE_DEPTH) ? IW'(TABLE_DEPTH) : IW'(r_count))
        : IW'(r_count);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_we = i_in_valid && o_in_ready && i_in_data.action == ACT_LOAD
        && 32'(i_in_data.table_index) < TABLE_DEPTH;
    assign w_sq = w_rdata * w_rdata;

    tpfc_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(i_in_data.table_index)),
        .i_wdata(i_in_data.prime_value), .i_raddr(r_idx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    tpfc_div #(.NB(NB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_dctl), .i_num(n_rem),
        .i_den(n_p), .o_done(w_ddone), .o_quo(w_quo), .o_rem(w_drem)
    );

    always_comb begin
        w_tot = r_nf + ((r_rem > NB'(1)) ? 2'd1 : 2'd0);
        w_lo = r_f0;
        w_hi = (r_nf == 2'd2) ? r_f1 : r_rem;
        if (w_hi < w_lo) begin
            w_lo = w_hi;
            w_hi = r_f0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_rem = r_rem;
        n_f0 = r_f0;
        n_f1 = r_f1;
        n_p = r_p;
        n_nf = r_nf;
        n_hit = r_hit;
        n_many = r_many;
        n_out = r_out;
        n_ovalid = r_ovalid && !i_out_ready;
        w_dctl = '0;
        w_dctl.busy = r_state == S_DIV;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready && i_in_data.action == ACT_CLASSIFY) begin
                    n_rem = NB'(i_in_data.number);
                    n_idx = '0;
                    n_nf = '0;
                    n_f0 = '0;
                    n_f1 = '0;
                    n_many = 1'b0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = (r_idx >= w_limit) ? S_DONE : S_TEST;
            end
            S_TEST: begin
                n_p = NB'(w_rdata);
                if (w_rdata < VALUE_W'(2)) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_READ;
                end else if (64'(w_sq) > 64'(r_rem)) begin
                    n_state = S_DONE;
                end else begin
                    n_hit = 1'b0;
                    w_dctl.start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_ddone) begin
                    if (w_drem == '0) begin
                        n_rem = w_quo;
                        n_hit = 1'b1;
                        w_dctl.start = 1'b1;
                    end else begin
                        if (r_hit) begin
                            if (r_nf == 2'd0) n_f0 = r_p;
                            else n_f1 = r_p;
                            n_nf = r_nf + 1'b1;
                            if (r_nf == 2'd1 && r_rem != NB'(1)) n_many = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                        n_state = (r_hit && r_nf == 2'd1 && r_rem != NB'(1))
                            ? S_DONE : S_READ;
                    end
                end
            end
            S_DONE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    if (r_many) n_out.kind = KIND_OTHER;
                    else if (r_nf == 2'd0 && r_rem > NB'(1)) n_out.kind = KIND_PRIME;
                    else if (w_tot == 2'd2) begin
                        n_out.kind = KIND_TWO;
                        n_out.smaller_prime = NUM_W'(w_lo);
                        n_out.larger_prime = NUM_W'(w_hi);
                    end else n_out.kind = KIND_OTHER;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
        end
        r_idx <= n_idx;
        r_rem <= n_rem;
        r_f0 <= n_f0;
        r_f1 <= n_f1;
        r_p <= n_p;
        r_nf <= n_nf;
        r_hit <= n_hit;
        r_many <= n_many;
        r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_TWO |->
        o_out_data.smaller_prime == '0 && o_out_data.larger_prime == '0)
        else $error("factors set for wrong kind");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_in_ready)
        else $error("input taken while busy");
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tpfc_pkg::*;

    localparam int DEPTH = 512;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_word i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_word o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    bit [VALUE_W-1:0] prime_list[DEPTH];
    bit [VALUE_W-1:0] shadow_table[DEPTH];
    int unsigned shadow_count;
    t_out_word pending_kinds[$];
    int errors = 0;
    bit calm = 1'b0;

    two_prime_factor_classifier dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_word classify_number(logic [NUM_W-1:0] n);
        longint unsigned rem, p, f0, f1;
        int nf, total, lim;
        bit many;
        t_out_word r;
        rem = n;
        f0 = 0;
        f1 = 0;
        nf = 0;
        many = 1'b0;
        lim = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
        for (int i = 0; i < lim; i++) begin
            p = shadow_table[i];
            if (p < 2) continue;
            if (p * p > rem) break;
            if (rem % p == 0) begin
                while (rem % p == 0) rem = rem / p;
                if (nf == 0) f0 = p;
                else if (nf == 1) f1 = p;
                nf++;
                if (nf >= 2 && rem != 1) begin
                    many = 1'b1;
                    break;
                end
            end
        end
        r = '0;
        r.kind = KIND_OTHER;
        if (!many) begin
            if (nf == 0 && rem > 1) begin
                r.kind = KIND_PRIME;
            end else begin
                total = nf;
                if (rem > 1) begin
                    if (total == 0) f0 = rem;
                    else if (total == 1) f1 = rem;
                    total++;
                end
                if (total == 2) begin
                    r.kind = KIND_TWO;
                    r.smaller_prime = NUM_W'((f0 < f1) ? f0 : f1);
                    r.larger_prime = NUM_W'((f0 < f1) ? f1 : f0);
                end
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_kinds.size() == 0) begin
                $display("%0t: unexpected word kind=%0d %0d %0d", $realtime,
                         o_out_data.kind, o_out_data.smaller_prime, o_out_data.larger_prime);
                errors++;
            end else begin
                t_out_word exp_w;
                exp_w = pending_kinds.pop_front();
                if (o_out_data.kind !== exp_w.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $realtime,
                             exp_w.kind, o_out_data.kind);
                    errors++;
                end
                if (o_out_data.smaller_prime !== exp_w.smaller_prime) begin
                    $display("%0t: smaller_prime expected %0d actual %0d", $realtime,
                             exp_w.smaller_prime, o_out_data.smaller_prime);
                    errors++;
                end
                if (o_out_data.larger_prime !== exp_w.larger_prime) begin
                    $display("%0t: larger_prime expected %0d actual %0d", $realtime,
                             exp_w.larger_prime, o_out_data.larger_prime);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    task automatic send_word(t_in_word w);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (w.action == ACT_LOAD) shadow_table[w.table_index] = w.prime_value;
        else pending_kinds = {pending_kinds, classify_number(w.number)};
    endtask

    task automatic load_slot(int idx, int val);
        t_in_word w;
        w = '0;
        w.action = ACT_LOAD;
        w.table_index = INDEX_W'(idx);
        w.prime_value = VALUE_W'(val);
        w.number = NUM_W'($urandom());
        send_word(w);
    endtask

    task automatic classify(int unsigned n);
        t_in_word w;
        w.action = ACT_CLASSIFY;
        w.table_index = INDEX_W'($urandom());
        w.prime_value = VALUE_W'($urandom());
        w.number = NUM_W'(n);
        send_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_kinds.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_count(int unsigned c);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= COUNT_W'(c);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_count = c;
    endtask

    task automatic test_empty_table();
        classify(0);
        classify(1);
        classify(2);
        classify(12);
        classify(24'hFFFFFF);
    endtask

    task automatic test_table_load();
        calm = 1'b1;
        for (int i = 0; i < DEPTH; i++) load_slot(i, prime_list[i]);
        calm = 1'b0;
        set_count(DEPTH);
    endtask

    task automatic test_factor_shapes();
        classify(2);
        classify(3);
        classify(4);
        classify(6);
        classify(30);
        classify(49 * 11);
        classify(16777213);
        classify(24'hFFFFFF);
        classify(3671 * 3673);
        classify(2 * 8388593);
        classify(4093 * 4099);
        classify(1024 * 81);
    endtask

    task automatic test_table_quirks();
        set_count(1023);
        classify(3673 * 4001);
        set_count(1);
        classify(2 * 3 * 5);
        classify(8 * 7);
        set_count(0);
        classify(15);
        load_slot(0, 1);
        load_slot(1, 0);
        load_slot(2, 7);
        load_slot(3, 3);
        set_count(5);
        classify(21);
        classify(7 * 9 * 11);
        for (int i = 0; i < 4; i++) load_slot(i, prime_list[i]);
        set_count(DEPTH);
    endtask

    task automatic test_random_mix();
        int unsigned counts[9] = '{0, 1, 2, 10, 100, 511, 512, 700, 1023};
        longint unsigned n, p, q;
        for (int k = 0; k < 300; k++) begin
            if (k % 60 == 59) begin
                set_count(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                     : counts[$urandom_range(0, 8)]);
                if ($urandom_range(0, 1)) begin
                    for (int i = 0; i < DEPTH; i++) shadow_table[i] = shadow_table[i];
                end
            end
            if (k == 150) calm = 1'b1;
            if (k == 200) calm = 1'b0;
            if (k == 120) drain();
            case ($urandom_range(0, 9))
                0: begin
                    if ($urandom_range(0, 3) == 0) load_slot($urandom_range(0, DEPTH - 1),
                                                             $urandom_range(0, 65535));
                    else begin
                        int idx;
                        idx = $urandom_range(0, DEPTH - 1);
                        load_slot(idx, prime_list[idx]);
                    end
                end
                1: classify($urandom_range(0, 24'hFFFFFF));
                2: classify($urandom_range(0, 200));
                default: begin
                    p = prime_list[$urandom_range(0, DEPTH - 1)];
                    q = prime_list[$urandom_range(0, 60)];
                    n = p * q;
                    if ($urandom_range(0, 2) == 0) n = n * q;
                    if ($urandom_range(0, 3) == 0) n = n * prime_list[$urandom_range(0, 20)];
                    if ($urandom_range(0, 4) == 0) n = p * p;
                    if (n > 24'hFFFFFF) n = p * 2;
                    classify(32'(n));
                end
            endcase
        end
    endtask

    initial begin
        int cnt, v;
        bit is_p;
        cnt = 0;
        v = 2;
        while (cnt < DEPTH) begin
            is_p = 1'b1;
            for (int d = 2; d * d <= v; d++) if (v % d == 0) is_p = 1'b0;
            if (is_p) begin
                prime_list[cnt] = VALUE_W'(v);
                cnt++;
            end
            v++;
        end
        shadow_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_table_load();
        test_factor_shapes();
        test_table_quirks();
        test_random_mix();
        drain();
        if (errors == 0) $display("two_prime_factor_classifier regression: pass");
        else $display("two_prime_factor_classifier regression: fail");
        $finish;
    end

    initial begin
        #60000000;
        $display("two_prime_factor_classifier regression: fail");
        $finish;
    end

endmodule
